// File: rtl/core/led_key_panel_command_framer_defines.svh
// Assertion macros shared by the panel command framer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef LED_KEY_PANEL_COMMAND_FRAMER_DEFINES_SVH
`define LED_KEY_PANEL_COMMAND_FRAMER_DEFINES_SVH

// same-cycle implication, reset masked
`define LKP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lkp assertion failed");

// next-cycle implication, reset masked
`define LKP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lkp assertion failed");

`endif

// File: rtl/core/lkp_pkg.sv
// Types and constants for the panel command framer.
// No dependencies; imported by every module of the block.
package lkp_pkg;

  // panel command codes
  typedef enum logic [3:0] {
    ACT_HEX        = 4'd0,
    ACT_RAW        = 4'd1,
    ACT_CLEAR      = 4'd2,
    ACT_LED        = 4'd3,
    ACT_LEDS       = 4'd4,
    ACT_ON         = 4'd5,
    ACT_OFF        = 4'd6,
    ACT_BRIGHTNESS = 4'd7,
    ACT_BLANK      = 4'd8,
    ACT_READKEYS   = 4'd9
  } action_t;

  // shape of the byte run a command produces
  typedef enum logic [2:0] {
    KIND_SINGLE,
    KIND_PAIR,
    KIND_CLEAR,
    KIND_LEDS,
    KIND_BLANK
  } cmd_kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  localparam logic [7:0] INSTR_WRITE_INC   = 8'h40;
  localparam logic [7:0] INSTR_READ_KEYS   = 8'h42;
  localparam logic [7:0] INSTR_WRITE_FIXED = 8'h44;
  localparam logic [7:0] ADDR_BASE         = 8'hC0;
  localparam logic [7:0] MODE_OFF          = 8'h80;
  localparam logic [7:0] MODE_ON           = 8'h88;

  localparam int unsigned IDX_W = 5;

  localparam logic [IDX_W-1:0] LAST_SINGLE = 5'd0;
  localparam logic [IDX_W-1:0] LAST_PAIR   = 5'd3;
  localparam logic [IDX_W-1:0] LAST_SWEEP  = 5'd17;
  localparam logic [IDX_W-1:0] LAST_BLANK  = 5'd18;

  // decoded command handed from front to back
  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       mode;      // first byte of every run
    logic [7:0]       instr;     // second byte of multi-byte runs
    logic [7:0]       addr;
    logic [7:0]       data;      // data byte, or LED mask for the sweep
    logic             is_read;
    logic [7:0]       buttons;
    logic [IDX_W-1:0] last_idx;
  } lkp_cmd_t;

  // seven-segment patterns for hex digits
  function automatic logic [7:0] seg_pattern(input logic [3:0] nib);
    logic [7:0] s;
    case (nib)
      4'h0: s = 8'h3F;  4'h1: s = 8'h06;  4'h2: s = 8'h5B;  4'h3: s = 8'h4F;
      4'h4: s = 8'h66;  4'h5: s = 8'h6D;  4'h6: s = 8'h7D;  4'h7: s = 8'h07;
      4'h8: s = 8'h7F;  4'h9: s = 8'h6F;  4'hA: s = 8'h77;  4'hB: s = 8'h7C;
      4'hC: s = 8'h39;  4'hD: s = 8'h5E;  4'hE: s = 8'h79;  4'hF: s = 8'h71;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/core/lkp_front.sv
// Front end: checks and decodes panel commands, holds display state.
// Depends on lkp_pkg; feeds lkp_queue.
module lkp_front import lkp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [3:0] action,
  input  logic [3:0] position,
  input  logic [7:0] value,
  input  logic [31:0] key_bytes,
  output logic       q_push,
  output lkp_cmd_t   q_data
);

  logic       display_on_r, display_on_nxt;
  logic [2:0] pulse_width_r, pulse_width_nxt;
  logic       ok;
  lkp_cmd_t   cmd;
  logic [7:0] btn;

  // fold the four key bytes, each shifted by its index
  assign btn = key_bytes[7:0]
             | {key_bytes[14:8], 1'b0}
             | {key_bytes[21:16], 2'b0}
             | {key_bytes[28:24], 3'b0};

  // classify
  always_comb begin
    ok              = 1'b0;
    display_on_nxt  = display_on_r;
    pulse_width_nxt = pulse_width_r;
    cmd.kind        = KIND_SINGLE;
    cmd.mode        = MODE_ON | {5'b0, pulse_width_r};
    cmd.instr       = INSTR_WRITE_FIXED;
    cmd.addr        = ADDR_BASE;
    cmd.data        = 8'h00;
    cmd.is_read     = 1'b0;
    cmd.buttons     = 8'h00;
    cmd.last_idx    = LAST_SINGLE;
    case (action)
      ACT_HEX, ACT_RAW: begin
        ok           = !position[3] && !(action == ACT_HEX && value[7:4] != 4'h0);
        cmd.kind     = KIND_PAIR;
        cmd.addr     = 8'hCE - {4'b0, position[2:0], 1'b0};
        cmd.data     = (action == ACT_HEX) ? seg_pattern(value[3:0]) : value;
        cmd.last_idx = LAST_PAIR;
      end
      ACT_CLEAR: begin
        ok           = 1'b1;
        cmd.kind     = KIND_CLEAR;
        cmd.last_idx = LAST_SWEEP;
      end
      ACT_LED: begin
        ok           = position != 4'd0 && position <= 4'd8;
        cmd.kind     = KIND_PAIR;
        cmd.addr     = 8'hBF + {3'b0, position, 1'b0};
        cmd.data     = {7'b0, value != 8'h00};
        cmd.last_idx = LAST_PAIR;
      end
      ACT_LEDS: begin
        ok           = 1'b1;
        cmd.kind     = KIND_LEDS;
        cmd.data     = value;
        cmd.last_idx = LAST_SWEEP;
      end
      ACT_ON: begin
        ok             = 1'b1;
        display_on_nxt = 1'b1;
      end
      ACT_OFF: begin
        ok             = 1'b1;
        cmd.mode       = MODE_OFF | {5'b0, pulse_width_r};
        display_on_nxt = 1'b0;
      end
      ACT_BRIGHTNESS: begin
        ok              = value[7:3] == 5'd0;
        pulse_width_nxt = ok ? value[2:0] : pulse_width_r;
        cmd.mode        = (display_on_r ? MODE_ON : MODE_OFF) | {5'b0, value[2:0]};
      end
      ACT_BLANK: begin
        ok           = 1'b1;
        cmd.kind     = KIND_BLANK;
        cmd.instr    = INSTR_WRITE_INC;
        cmd.last_idx = LAST_BLANK;
      end
      ACT_READKEYS: begin
        ok          = 1'b1;
        cmd.mode    = INSTR_READ_KEYS;
        cmd.is_read = 1'b1;
        cmd.buttons = btn;
      end
      default: ok = 1'b0;
    endcase
  end

  assign q_push = accept && ok;
  assign q_data = cmd;

  // display state; unknown codes leave it alone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_on_r  <= 1'b0;
      pulse_width_r <= 3'd0;
    end else if (accept) begin
      display_on_r  <= display_on_nxt;
      pulse_width_r <= pulse_width_nxt;
    end
  end

endmodule

// File: rtl/core/lkp_queue.sv
// Short command queue between front and back end.
// Depends on lkp_pkg for the command type.
module lkp_queue import lkp_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  lkp_cmd_t wdata,
  output logic     full,
  input  logic     pop,
  output lkp_cmd_t rdata,
  output logic     empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lkp_cmd_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = cnt_r == CNT_W'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: rtl/core/lkp_back.sv
// Back end: walks a decoded command byte by byte into the output register.
// Depends on lkp_pkg and the assertion macros header.
`include "led_key_panel_command_framer_defines.svh"
module lkp_back import lkp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  lkp_cmd_t   q_data,
  output logic       q_pop,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] tx_byte,
  output logic       frame_end,
  output logic       is_read,
  output logic [7:0] buttons,
  output logic       last
);

  back_state_t      st_r, st_nxt;
  lkp_cmd_t         cur_r;
  logic [IDX_W-1:0] idx_r, k;
  logic             load, is_last;
  logic [7:0]       g_byte;
  logic             g_end;
  logic             ov_r;
  logic [7:0]       tx_r, btn_r;
  logic             end_r, rd_r, last_r;

  assign is_last = idx_r == cur_r.last_idx;
  assign k       = idx_r - IDX_W'(2);

  // byte for the current position of the run
  always_comb begin
    g_byte = 8'h00;
    g_end  = 1'b1;
    if (idx_r == '0) begin
      g_byte = cur_r.mode;
    end else if (idx_r == IDX_W'(1)) begin
      g_byte = cur_r.instr;
    end else begin
      case (cur_r.kind)
        KIND_PAIR: begin
          g_byte = k[0] ? cur_r.data : cur_r.addr;
          g_end  = k[0];
        end
        KIND_CLEAR: begin
          g_byte = k[0] ? 8'h00 : (ADDR_BASE | {4'b0, k[3:0]});
          g_end  = k[0];
        end
        KIND_LEDS: begin
          g_byte = k[0] ? {7'b0, cur_r.data[k[3:1]]}
                        : (ADDR_BASE | {4'b0, k[3:1], 1'b1});
          g_end  = k[0];
        end
        KIND_BLANK: begin
          g_byte = (k == '0) ? ADDR_BASE : 8'h00;
          g_end  = is_last;
        end
        default: begin
          g_byte = 8'h00;
          g_end  = 1'b1;
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    st_nxt = st_r;
    q_pop  = 1'b0;
    load   = 1'b0;
    case (st_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop  = 1'b1;
          st_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (!ov_r || pop) begin
          load = 1'b1;
          if (is_last) begin
            st_nxt = BK_IDLE;
          end
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (load) begin
        ov_r <= 1'b1;
      end else if (pop) begin
        ov_r <= 1'b0;
      end
    end
  end

  // command hold and output beat register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
      idx_r <= '0;
    end else if (load) begin
      idx_r <= idx_r + 1'b1;
    end
    if (load) begin
      tx_r   <= g_byte;
      end_r  <= g_end;
      rd_r   <= cur_r.is_read;
      btn_r  <= cur_r.buttons;
      last_r <= is_last;
    end
  end

  assign empty     = !ov_r;
  assign tx_byte   = tx_r;
  assign frame_end = end_r;
  assign is_read   = rd_r;
  assign buttons   = btn_r;
  assign last      = last_r;

  `LKP_ASSERT_IMPLY(a_idx_in_run, clk, rst_n, st_r == BK_RUN, idx_r <= cur_r.last_idx)
  `LKP_ASSERT_IMPLY(a_last_ends_frame, clk, rst_n, ov_r && last_r, end_r)
  `LKP_ASSERT_IMPLY(a_read_single, clk, rst_n, ov_r && rd_r, last_r)
  `LKP_ASSERT_IMPLY(a_btn_zero, clk, rst_n, ov_r && !rd_r, btn_r == 8'h00)
  `LKP_ASSERT_NEXT(a_run_done, clk, rst_n, load && is_last, st_r == BK_IDLE)

endmodule

// File: rtl/core/led_key_panel_command_framer.sv
// Top level of the panel command framer: front end, queue, back end.
// Depends on lkp_pkg, lkp_front, lkp_queue and lkp_back.
//
//  channel  | handshake        | beat
//  ---------+------------------+--------------------------------------------
//  input    | push / full      | action, position, value, key_bytes
//  result   | pop / empty      | tx_byte, frame_end, is_read, buttons, last
//
// A command is taken while the queue has room; rejected ones
// leave nothing behind. The back end picks a command off the queue in
// its idle state and then emits one byte per cycle while the result
// is popped or its output register is empty.
// Reset is synchronous, active low, and empties queue and output register.
// A stalled result holds the back end; the front keeps taking commands
// until the queue fills.
module led_key_panel_command_framer import lkp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [3:0]  in_action,
  input  logic [3:0]  in_position,
  input  logic [7:0]  in_value,
  input  logic [31:0] in_key_bytes,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_tx_byte,
  output logic        out_frame_end,
  output logic        out_is_read,
  output logic [7:0]  out_buttons,
  output logic        out_last
);

  logic     accept;
  logic     q_push, q_pop, q_empty;
  lkp_cmd_t q_wdata, q_rdata;

  assign accept = push && !full;

  lkp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .action    (in_action),
    .position  (in_position),
    .value     (in_value),
    .key_bytes (in_key_bytes),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  lkp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  lkp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .tx_byte   (out_tx_byte),
    .frame_end (out_frame_end),
    .is_read   (out_is_read),
    .buttons   (out_buttons),
    .last      (out_last)
  );

endmodule

// File: verif/tb_top.sv
// Self-checking bench for led_key_panel_command_framer: directed table, then random commands.
// Each accepted command is run through a local byte-run predictor and every popped beat is
// checked in order. Depends on lkp_pkg and the framer RTL only.
module tb_top import lkp_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // codes outside the command set, used for rejects
  localparam logic [3:0] ACT_BAD_LO = 4'd10;
  localparam logic [3:0] ACT_BAD_HI = 4'd15;

  localparam int DIRECTED_N = 25;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;

  // own copy of the digit glyphs
  localparam logic [7:0] SEG_GLYPH [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
  };

  typedef struct packed {
    logic [3:0]  action;
    logic [3:0]  position;
    logic [7:0]  value;
    logic [31:0] keys;
  } panel_cmd_t;

  typedef struct packed {
    logic [7:0] tx;
    logic       fe;
    logic       rd;
    logic [7:0] btn;
    logic       last;
  } panel_byte_t;

  // one stimulus row; typed rows carry their single result (or none) by hand
  typedef struct packed {
    panel_cmd_t cmd;
    logic       typed;
    logic       t_emits;
    logic [7:0] t_byte;
    logic [7:0] t_btn;
  } panel_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [3:0]  in_action;
  logic [3:0]  in_position;
  logic [7:0]  in_value;
  logic [31:0] in_key_bytes;
  logic        empty;
  logic        pop;
  logic [7:0]  out_tx_byte;
  logic        out_frame_end;
  logic        out_is_read;
  logic [7:0]  out_buttons;
  logic        out_last;

  // predictor state
  logic       panel_on;
  logic [2:0] panel_pw;
  panel_byte_t run_q[$];

  // bytes still owed by the block, oldest first
  panel_byte_t frame_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int mismatches;
  int commands;
  int rejected;
  int bytes_checked;
  int full_waits;

  panel_row_t plan [DIRECTED_N] = '{
    '{'{ACT_ON,         4'd0,  8'd0,   32'h0},        1'b1, 1'b1, 8'h88, 8'h00},
    '{'{ACT_BRIGHTNESS, 4'd0,  8'd7,   32'h0},        1'b1, 1'b1, 8'h8F, 8'h00},
    '{'{ACT_BRIGHTNESS, 4'd0,  8'd8,   32'h0},        1'b1, 1'b0, 8'h00, 8'h00},
    '{'{ACT_BRIGHTNESS, 4'd15, 8'd255, 32'hFFFFFFFF}, 1'b1, 1'b0, 8'h00, 8'h00},
    '{'{ACT_OFF,        4'd15, 8'd255, 32'hFFFFFFFF}, 1'b1, 1'b1, 8'h87, 8'h00},
    '{'{ACT_BRIGHTNESS, 4'd0,  8'd0,   32'h0},        1'b1, 1'b1, 8'h80, 8'h00},
    '{'{ACT_HEX,        4'd0,  8'd0,   32'h0},        1'b0, 1'b0, 8'h00, 8'h00},
    '{'{ACT_HEX,        4'd7,  8'd15,  32'h0},        1'b0, 1'b0, 8'h00, 8'h00},
    '{'{ACT_HEX,        4'd8,  8'd3,   32'h0},        1'b1, 1'b0, 8'h00, 8'h00},
    '{'{ACT_HEX,        4'd3,  8'd16,  32'h0},        1'b1, 1'b0, 8'h00, 8'h00},
    '{'{ACT_RAW,        4'd15, 8'hFF,  32'h0},        1'b1, 1'b0, 8'h00, 8'h00},
    '{'{ACT_RAW,        4'd0,  8'hFF,  32'h0},        1'b0, 1'b0, 8'h00, 8'h00},
    '{'{ACT_RAW,        4'd7,  8'h00,  32'h0},        1'b0, 1'b0, 8'h00, 8'h00},
    '{'{ACT_CLEAR,      4'd15, 8'hFF,  32'hFFFFFFFF}, 1'b0, 1'b0, 8'h00, 8'h00},
    '{'{ACT_LED,        4'd0,  8'd1,   32'h0},        1'b1, 1'b0, 8'h00, 8'h00},
    '{'{ACT_LED,        4'd9,  8'd1,   32'h0},        1'b1, 1'b0, 8'h00, 8'h00},
    '{'{ACT_LED,        4'd1,  8'd0,   32'h0},        1'b0, 1'b0, 8'h00, 8'h00},
    '{'{ACT_LED,        4'd8,  8'hFF,  32'h0},        1'b0, 1'b0, 8'h00, 8'h00},
    '{'{ACT_LEDS,       4'd0,  8'hA5,  32'h0},        1'b0, 1'b0, 8'h00, 8'h00},
    '{'{ACT_BLANK,      4'd0,  8'h00,  32'h0},        1'b0, 1'b0, 8'h00, 8'h00},
    '{'{ACT_READKEYS,   4'd0,  8'h00,  32'h0},        1'b1, 1'b1, 8'h42, 8'h00},
    '{'{ACT_READKEYS,   4'd15, 8'hFF,  32'hFFFFFFFF}, 1'b1, 1'b1, 8'h42, 8'hFF},
    '{'{ACT_BAD_LO,     4'd3,  8'd3,   32'h12345678}, 1'b1, 1'b0, 8'h00, 8'h00},
    '{'{ACT_BAD_HI,     4'd15, 8'hFF,  32'hFFFFFFFF}, 1'b1, 1'b0, 8'h00, 8'h00},
    '{'{ACT_READKEYS,   4'd0,  8'h00,  32'h01020408}, 1'b0, 1'b0, 8'h00, 8'h00}
  };

  led_key_panel_command_framer uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_action     (in_action),
    .in_position   (in_position),
    .in_value      (in_value),
    .in_key_bytes  (in_key_bytes),
    .empty         (empty),
    .pop           (pop),
    .out_tx_byte   (out_tx_byte),
    .out_frame_end (out_frame_end),
    .out_is_read   (out_is_read),
    .out_buttons   (out_buttons),
    .out_last      (out_last)
  );

  always #5 clk = ~clk;

  // hard stop in case the block wedges
  initial begin
    #10_000_000;
    $display("timeout: %0d bytes still owed", frame_q.size());
    $display("status: fail");
    $finish;
  end

  task automatic note_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // predictor: append one plain byte (no key data) to the run being built
  function automatic void add_byte(input logic [7:0] b, input logic fe);
    run_q.push_back('{b, fe, 1'b0, 8'h00, 1'b0});
  endfunction

  // mode byte then instruction, both strobed
  function automatic void open_write(input logic [7:0] instr);
    add_byte(MODE_ON | {5'b0, panel_pw}, 1'b1);
    add_byte(instr, 1'b1);
  endfunction

  // builds the byte run for one command into run_q and updates the panel state
  function automatic int frame_command(input panel_cmd_t c);
    logic [7:0] addr;
    logic [7:0] mask;
    logic [7:0] btn;
    int k;
    run_q.delete();
    case (c.action)
      ACT_HEX, ACT_RAW: begin
        if (c.position > 4'd7 || (c.action == ACT_HEX && c.value > 8'd15)) return 0;
        open_write(INSTR_WRITE_FIXED);
        add_byte(ADDR_BASE + 8'd14 - {3'b0, c.position, 1'b0}, 1'b0);
        add_byte(c.action == ACT_HEX ? SEG_GLYPH[c.value[3:0]] : c.value, 1'b1);
      end
      ACT_CLEAR: begin
        open_write(INSTR_WRITE_FIXED);
        addr = ADDR_BASE;
        for (k = 0; k < 8; k++) begin
          add_byte(addr, 1'b0);
          add_byte(8'h00, 1'b1);
          addr += 8'd2;
        end
      end
      ACT_LED: begin
        if (c.position < 4'd1 || c.position > 4'd8) return 0;
        open_write(INSTR_WRITE_FIXED);
        add_byte(ADDR_BASE + {3'b0, c.position, 1'b0} - 8'd1, 1'b0);
        add_byte({7'b0, c.value != 8'd0}, 1'b1);
      end
      ACT_LEDS: begin
        open_write(INSTR_WRITE_FIXED);
        addr = ADDR_BASE + 8'd1;
        mask = c.value;
        for (k = 0; k < 8; k++) begin
          add_byte(addr, 1'b0);
          add_byte({7'b0, mask[0]}, 1'b1);
          mask = mask >> 1;
          addr += 8'd2;
        end
      end
      ACT_ON: begin
        add_byte(MODE_ON | {5'b0, panel_pw}, 1'b1);
        panel_on = 1'b1;
      end
      ACT_OFF: begin
        add_byte(MODE_OFF | {5'b0, panel_pw}, 1'b1);
        panel_on = 1'b0;
      end
      ACT_BRIGHTNESS: begin
        if (c.value > 8'd7) return 0;
        panel_pw = c.value[2:0];
        add_byte((panel_on ? MODE_ON : MODE_OFF) | {5'b0, panel_pw}, 1'b1);
      end
      ACT_BLANK: begin
        open_write(INSTR_WRITE_INC);
        add_byte(ADDR_BASE, 1'b0);
        for (k = 0; k < 16; k++) add_byte(8'h00, k == 15);
      end
      ACT_READKEYS: begin
        // key byte i lands shifted by i, high bits fall off
        btn = 8'h00;
        for (k = 0; k < 4; k++) btn = btn | (c.keys[k*8 +: 8] << k);
        run_q.push_back('{INSTR_READ_KEYS, 1'b1, 1'b1, btn, 1'b0});
      end
      default: return 0;
    endcase
    return run_q.size();
  endfunction

  // offer one command; called and returns at a falling edge
  task automatic offer(input panel_row_t row);
    panel_byte_t b;
    int n;
    int k;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push         <= 1'b1;
    in_action    <= row.cmd.action;
    in_position  <= row.cmd.position;
    in_value     <= row.cmd.value;
    in_key_bytes <= row.cmd.keys;
    @(posedge clk);
    while (full) begin
      full_waits++;
      @(posedge clk);
    end
    n = frame_command(row.cmd);
    commands++;
    if (n == 0) rejected++;
    if (row.typed) begin
      if (row.t_emits)
        frame_q.push_back('{row.t_byte, 1'b1, row.cmd.action == ACT_READKEYS,
                            row.t_btn, 1'b1});
    end else begin
      for (k = 0; k < n; k++) begin
        b = run_q[k];
        b.last = (k == n - 1);
        frame_q.push_back(b);
      end
    end
    @(negedge clk);
  endtask

  // random commands, mostly well formed, with a share of bad codes and operands
  task automatic run_phase(input int s_pct, input int r_pct, input int count);
    panel_row_t row;
    int i;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (i = 0; i < count; i++) begin
      row = '0;
      row.cmd.action = ($urandom_range(0, 99) < 8) ?
                       4'($urandom_range(ACT_BAD_LO, ACT_BAD_HI)) : 4'($urandom_range(0, 9));
      row.cmd.position = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 99) < 85) begin
        case (row.cmd.action)
          ACT_HEX, ACT_RAW: row.cmd.position = 4'($urandom_range(0, 7));
          ACT_LED:          row.cmd.position = 4'($urandom_range(1, 8));
          default: ;
        endcase
      end
      row.cmd.value = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 80) begin
        case (row.cmd.action)
          ACT_HEX:        row.cmd.value = 8'($urandom_range(0, 15));
          ACT_BRIGHTNESS: row.cmd.value = 8'($urandom_range(0, 7));
          default: ;
        endcase
      end
      row.cmd.keys = $urandom;
      offer(row);
    end
  endtask

  // receiver: random pops, or a long hold-off when asked for one
  initial begin
    int stall_left;
    stall_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // check every popped beat against the oldest owed byte
  always @(posedge clk) begin
    panel_byte_t e;
    if (rst_n === 1'b1 && pop && !empty) begin
      if (frame_q.size() == 0) begin
        note_mismatch("unexpected byte", out_tx_byte, 0);
      end else begin
        e = frame_q.pop_front();
        bytes_checked++;
        if (out_tx_byte !== e.tx)     note_mismatch("tx_byte", out_tx_byte, e.tx);
        if (out_frame_end !== e.fe)   note_mismatch("frame_end", out_frame_end, e.fe);
        if (out_is_read !== e.rd)     note_mismatch("is_read", out_is_read, e.rd);
        if (out_buttons !== e.btn)    note_mismatch("buttons", out_buttons, e.btn);
        if (out_last !== e.last)      note_mismatch("last", out_last, e.last);
      end
    end
  end

  initial begin
    int r;
    rst_n = 1'b0;
    push = 1'b0;
    in_action = '0;
    in_position = '0;
    in_value = '0;
    in_key_bytes = '0;
    panel_on = 1'b0;
    panel_pw = 3'd0;
    hold_req = 1'b0;
    mismatches = 0;
    commands = 0;
    rejected = 0;
    bytes_checked = 0;
    full_waits = 0;
    send_idle_pct = 26;
    recv_idle_pct = 59;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    for (r = 0; r < DIRECTED_N; r++) offer(plan[r]);

    // random: slow receiver, then slow sender, then flat out behind a long hold-off
    run_phase(26, 59, 112);
    run_phase(59, 26, 112);
    hold_req = 1'b1;
    run_phase(0, 0, 112);
    push <= 1'b0;

    while (frame_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d commands (%0d rejected), %0d panel bytes checked",
             commands, rejected, bytes_checked);
    $display("input held off by full for %0d cycles, %0d mismatches",
             full_waits, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: led_key_panel_command_framer.f
+incdir+rtl/core
rtl/core/lkp_pkg.sv
rtl/core/lkp_front.sv
rtl/core/lkp_queue.sv
rtl/core/lkp_back.sv
rtl/core/led_key_panel_command_framer.sv
verif/tb_top.sv
